@@ design/sidf_pkg.sv @@
// Shared types and constants for the sequence ID and frame number fixer.
package sidf_pkg;

  // Field widths.
  localparam int ID_W     = 16;
  localparam int FN_IN_W  = 4;
  localparam int FN_OUT_W = 3;
  localparam int ELIM_W   = 8;
  localparam int MAXF_W   = 3;
  localparam int IDB_W    = 5;
  localparam int LAST_W   = 17;
  localparam int SLOT_W   = 17;
  localparam int RC_W     = 8;
  // Width for frame numbers and slot positions in compares (covers 16 slots).
  localparam int FN_W     = 5;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  // Stream data widths, padded to whole bytes.
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  // Register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ERROR_LIMIT = 2'd0,
    REG_MAX_FRAMES  = 2'd1,
    REG_ID_BITS     = 2'd2,
    REG_LAST_ID     = 2'd3
  } reg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_UNCFG = 2'd2
  } status_t;

  // Register values plus the state clear request that a frame count write raises.
  typedef struct packed {
    logic [ELIM_W-1:0] error_limit;
    logic [MAXF_W-1:0] max_frames;
    logic [IDB_W-1:0]  id_bits;
    logic [LAST_W-1:0] last_id;
    logic              clear;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [ID_W-1:0]     fixed_id;
    logic [FN_OUT_W-1:0] fixed_frame;
    logic                fixed_valid;
    status_t             status;
  } result_t;

endpackage

@@ design/sidf_cfg_regs.sv @@
// Configuration register file with its write decode.
module sidf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sidf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sidf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sidf_pkg::cfg_t                   cfg
);

  logic [sidf_pkg::ELIM_W-1:0] error_limit;
  logic [sidf_pkg::MAXF_W-1:0] max_frames;
  logic [sidf_pkg::IDB_W-1:0]  id_bits;
  logic [sidf_pkg::LAST_W-1:0] last_id;
  logic                        clear;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit <= sidf_pkg::ELIM_W'(3);
      max_frames  <= '0;
      id_bits     <= sidf_pkg::IDB_W'(16);
      last_id     <= '1;
    end else begin
      if (cfg_we) begin
        case (sidf_pkg::reg_idx_t'(cfg_addr))
          sidf_pkg::REG_ERROR_LIMIT: error_limit <= cfg_wdata[sidf_pkg::ELIM_W-1:0];
          sidf_pkg::REG_MAX_FRAMES:  max_frames  <= cfg_wdata[sidf_pkg::MAXF_W-1:0];
          sidf_pkg::REG_ID_BITS:     id_bits <= cfg_wdata[sidf_pkg::IDB_W-1:0];
          sidf_pkg::REG_LAST_ID:     last_id <= cfg_wdata[sidf_pkg::LAST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // A frame count write clears the group state at the same edge.
  assign clear = cfg_we &&
                 (sidf_pkg::reg_idx_t'(cfg_addr) == sidf_pkg::REG_MAX_FRAMES);

  assign cfg.error_limit = error_limit;
  assign cfg.max_frames  = max_frames;
  assign cfg.id_bits     = id_bits;
  assign cfg.last_id     = last_id;
  assign cfg.clear       = clear;

endmodule

@@ design/sidf_fix_core.sv @@
// Group state and the single pass ID and frame repair logic.
module sidf_fix_core #(
  parameter int MAX_SLOTS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sidf_pkg::cfg_t                  cfg,
  input  logic                            fire,
  input  logic [sidf_pkg::ID_W-1:0]       cell_id,
  input  logic [sidf_pkg::FN_IN_W-1:0]    frame_number,
  output sidf_pkg::result_t               result
);

  localparam int PW = $clog2(MAX_SLOTS + 1);
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int FW = sidf_pkg::FN_W;

  // Group state.
  logic [sidf_pkg::SLOT_W-1:0] slot_id [MAX_SLOTS];
  logic [PW-1:0]               position;
  logic                        first_item;
  logic [sidf_pkg::RC_W-1:0]   repair_count;

  logic [FW-1:0]               mf;
  logic                        unconf;
  logic                        no_ref;
  logic [sidf_pkg::SLOT_W-1:0] grp;
  logic                        grp_found;
  logic                        take_grp;
  logic [sidf_pkg::IDB_W-1:0]  bits;
  logic [sidf_pkg::ID_W:0]     modulus;
  logic [sidf_pkg::ID_W:0]     wrapped;
  logic [sidf_pkg::ID_W+1:0]   diff;
  logic                        dup;
  logic                        jump;
  logic [sidf_pkg::ID_W:0]     seq_fix;
  logic [sidf_pkg::ID_W-1:0]   seq_id;
  logic [sidf_pkg::SLOT_W-1:0] place_id;
  logic [FW-1:0]               fn5;
  logic [FW-1:0]               pos5;
  logic [FW-1:0]               idx;
  logic [FW-1:0]               pos_after;
  logic [SW-1:0]               wr_idx;
  logic                        in_range;
  logic                        bad_fn;
  logic                        bad_id;
  logic                        both_bad;
  logic                        place_ok;
  logic                        full;
  logic [sidf_pkg::SLOT_W-1:0] out_id;
  logic [FW-1:0]               out_fn;
  logic                        bump;
  logic                        zero_rc;
  logic [sidf_pkg::RC_W-1:0]   repair_count_next;

  // Frames per group, limited to the slot count.
  assign mf = (FW'(cfg.max_frames) > FW'(MAX_SLOTS)) ? FW'(MAX_SLOTS) : FW'(cfg.max_frames);
  assign unconf = (cfg.max_frames == '0);
  assign no_ref = cfg.last_id[sidf_pkg::LAST_W-1];

  // Group ID: first filled slot within the group.
  always_comb begin
    grp       = '1;
    grp_found = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (!grp_found && (FW'(i) < mf) && !slot_id[i][sidf_pkg::SLOT_W-1]) begin
        grp       = slot_id[i];
        grp_found = 1'b1;
      end
    end
  end

  assign take_grp = grp_found && (grp[sidf_pkg::ID_W-1:0] <= cell_id);

  // Sequence check against the reference ID, modulo 2^bits.
  assign bits = (cfg.id_bits == '0) ? sidf_pkg::IDB_W'(1) :
                ((cfg.id_bits > sidf_pkg::IDB_W'(16)) ? sidf_pkg::IDB_W'(16) : cfg.id_bits);
  assign modulus = (sidf_pkg::ID_W+1)'(1) << bits;
  assign wrapped = (cell_id < cfg.last_id[sidf_pkg::ID_W-1:0]) ?
                   ({1'b0, cell_id} + modulus) : {1'b0, cell_id};
  assign diff = {1'b0, wrapped} - {2'b00, cfg.last_id[sidf_pkg::ID_W-1:0]};
  assign dup  = (diff == '0);
  assign jump = !diff[sidf_pkg::ID_W+1] && (diff > (sidf_pkg::ID_W+2)'(2));
  assign seq_fix = (dup || jump) ? ({1'b0, cfg.last_id[sidf_pkg::ID_W-1:0]} + 1'b1)
                                 : {1'b0, cell_id};
  assign seq_id  = seq_fix[sidf_pkg::ID_W-1:0] & modulus[sidf_pkg::ID_W-1:0] - 1'b1;

  assign place_id = (no_ref || take_grp) ? {1'b0, cell_id} : {1'b0, seq_id};

  // Frame placement within the group.
  always_comb begin
    fn5      = FW'(frame_number);
    pos5     = FW'(position);
    in_range = (fn5 != '0) && (fn5 <= mf);
    idx      = fn5 - 1'b1;
    bad_fn   = 1'b0;
    bad_id   = 1'b0;
    if (!first_item) begin
      if (pos5 != idx) begin
        bad_fn = 1'b1;
        idx    = pos5;
      end
      bad_id = (idx != '0) && (slot_id[0] != place_id);
    end
    both_bad  = bad_fn && bad_id;
    out_id    = (bad_id && !both_bad) ? slot_id[0] : place_id;
    out_fn    = (bad_fn && !both_bad) ? (pos5 + 1'b1) : fn5;
    pos_after = idx + 1'b1;
    full      = (pos_after >= mf);
    wr_idx    = (idx >= FW'(MAX_SLOTS)) ? SW'(MAX_SLOTS - 1) : idx[SW-1:0];
    place_ok  = in_range && !both_bad;
  end

  // Consecutive repair counting, saturating at its top value.
  always_comb begin
    bump    = 1'b0;
    zero_rc = 1'b0;
    if (!unconf && !no_ref) begin
      if (take_grp) begin
        bump = !place_ok;
      end else begin
        bump    = dup || jump;
        zero_rc = !(dup || jump);
      end
    end
    repair_count_next = repair_count;
    if (zero_rc) begin
      repair_count_next = '0;
    end else if (bump && (repair_count != '1)) begin
      repair_count_next = repair_count + 1'b1;
    end
  end

  // Result for the item now in the input register.
  always_comb begin
    result.fixed_valid = !unconf && in_range;
    result.fixed_id    = result.fixed_valid ? out_id[sidf_pkg::ID_W-1:0] : '0;
    result.fixed_frame = result.fixed_valid ? out_fn[sidf_pkg::FN_OUT_W-1:0] : '0;
    if (unconf) begin
      result.status = sidf_pkg::ST_UNCFG;
    end else if (no_ref) begin
      result.status = place_ok ? sidf_pkg::ST_OK : sidf_pkg::ST_FAIL;
    end else begin
      result.status = (repair_count_next >= cfg.error_limit) ? sidf_pkg::ST_FAIL
                                                             : sidf_pkg::ST_OK;
    end
  end

  // State update; a configuration clear takes priority.
  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_id[i] <= '1;
      end
      position     <= '0;
      first_item   <= 1'b1;
      repair_count <= '0;
    end else if (fire && !unconf) begin
      repair_count <= repair_count_next;
      if (in_range) begin
        first_item <= 1'b0;
        if (full) begin
          for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_id[i] <= '1;
          end
          position <= '0;
        end else begin
          slot_id[wr_idx] <= out_id;
          position        <= pos_after[PW-1:0];
        end
      end
    end
  end

endmodule

@@ design/sequence_id_frame_fixer_top.sv @@
// Top level of the sequence ID and frame number fixer.
// Each item passes through the input register and then the result register.
// One item per cycle while results are taken; the input register feeds the repair logic
// and the result register, and group state is updated as each item is processed.
// Reset (rst, synchronous, active high) empties all slots, sets the first item
// flag, zeroes the repair count and loads the register reset values.
module sequence_id_frame_fixer_top #(
  parameter int MAX_SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes.
  input  logic                             cfg_we,
  input  logic [sidf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sidf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sidf_pkg::S_DATA_W-1:0]    s_axis_tdata,  // cell_id[15:0], frame_number[19:16]
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sidf_pkg::M_DATA_W-1:0]    m_axis_tdata   // fixed_id[15:0], fixed_frame[18:16],
                                                          // fixed_valid[19], status[21:20]
);

  sidf_pkg::cfg_t    cfg;
  sidf_pkg::result_t result;

  logic                          in_vld;
  logic [sidf_pkg::ID_W-1:0]     in_id;
  logic [sidf_pkg::FN_IN_W-1:0]  in_fn;
  logic                          fire;
  logic                          out_vld;
  sidf_pkg::result_t             out_res;

  sidf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Process the held item whenever the result register can take it.
  assign fire          = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_id <= s_axis_tdata[sidf_pkg::ID_W-1:0];
      in_fn <= s_axis_tdata[sidf_pkg::ID_W +: sidf_pkg::FN_IN_W];
    end
  end

  sidf_fix_core #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fire         (fire),
    .cell_id      (in_id),
    .frame_number (in_fn),
    .result       (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {2'b00, out_res.status, out_res.fixed_valid,
                          out_res.fixed_frame, out_res.fixed_id};

endmodule

@@ design/sidf_checker.sv @@
// Port level checks for the fixer top level, with the bind that attaches them.
module sidf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sidf_pkg::M_DATA_W-1:0] m_axis_tdata
);

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Invalid results carry a zero ID and frame.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[19] |-> m_axis_tdata[18:0] == 19'd0)
    else $error("invalid result with nonzero ID or frame");

  // A not-configured status never comes with a valid result.
  a_uncfg_invalid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21:20] == 2'd2 |-> !m_axis_tdata[19])
    else $error("valid result while not configured");

  // A valid result has a frame number of at least one.
  a_valid_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[18:16] != 3'd0)
    else $error("valid result with frame zero");

  // No result is offered in the first cycle after reset is released.
  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result offered after reset");

endmodule

bind sequence_id_frame_fixer_top sidf_checker u_sidf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/tb_top.sv @@
// Testbench for the sequence ID and frame number fixer with a predictor.
`timescale 1ns / 1ps

module tb_top;
  import sidf_pkg::*;

  localparam int NUM_SLOTS   = 4;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_PHASES = 16;
  localparam int HOLD_PHASE  = 3;
  localparam int PAUSE_PHASE = 7;
  localparam int SETTLE      = 4;
  localparam int END_SETTLE  = 8;
  localparam int N_DIR       = 37;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;  // cell_id[15:0], frame_number[19:16]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;        // fixed_id[15:0], fixed_frame[18:16],
                                              // fixed_valid[19], status[21:20]

  sequence_id_frame_fixer_top #(
    .MAX_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copies and group state kept by the predictor.
  logic [ELIM_W-1:0]        conf_error_limit = 8'd3;
  logic [MAXF_W-1:0]        conf_max_frames  = 3'd0;
  logic [IDB_W-1:0]         conf_id_bits     = 5'd16;
  logic signed [LAST_W-1:0] conf_last_id     = -17'sd1;
  logic signed [SLOT_W-1:0] slot_ids [NUM_SLOTS];
  int                       group_pos;
  bit                       awaiting_first;
  logic [RC_W-1:0]          repair_run;

  // Expected results in transaction order, plus run statistics.
  result_t pending_fixes [$];
  int      n_errors   = 0;
  int      n_items    = 0;
  int      n_results  = 0;
  int      n_writes   = 0;
  int      n_flagged  = 0;
  int      n_uncfg    = 0;
  int      n_invalid  = 0;
  int      n_holds    = 0;
  bit      quiet      = 1'b0;
  bit      hold_req   = 1'b0;

  // Directed stimulus: register writes and items, some with the result typed in.
  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;
  typedef struct packed {
    row_kind_t            kind;
    reg_idx_t             idx;
    logic [CFG_DATA_W-1:0] value;
    logic [ID_W-1:0]      item_id;
    logic [FN_IN_W-1:0]   frame_no;
    logic                 typed;
    result_t              want;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    // Not configured after reset, including the field extremes.
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'h0000, 4'd1,  1'b1, '{16'h0, 3'd0, 1'b0, ST_UNCFG}},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'hFFFF, 4'd15, 1'b1, '{16'h0, 3'd0, 1'b0, ST_UNCFG}},
    // Two frames per group with no reference ID.
    '{ROW_WRITE, REG_MAX_FRAMES,  17'd2, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd5,    4'd1,  1'b1, '{16'd5, 3'd1, 1'b1, ST_OK}},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd5,    4'd2,  1'b1, '{16'd5, 3'd2, 1'b1, ST_OK}},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd9,    4'd2,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd7,    4'd2,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd3,    4'd0,  1'b1, '{16'h0, 3'd0, 1'b0, ST_FAIL}},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd3,    4'd2,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd4,    4'd1,  1'b0, '0},
    // Frame count above the slot count.
    '{ROW_WRITE, REG_MAX_FRAMES,  17'd7, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd100,  4'd1,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd100,  4'd2,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd100,  4'd3,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd100,  4'd4,  1'b0, '0},
    // Reference ID known: duplicates, jumps and out of range frames.
    '{ROW_WRITE, REG_LAST_ID,     17'd100, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd101,  4'd1,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd101,  4'd2,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd100,  4'd3,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd200,  4'd4,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd250,  4'd1,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd7,    4'd2,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd300,  4'd9,  1'b0, '0},
    '{ROW_WRITE, REG_ERROR_LIMIT, 17'd0, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd102,  4'd4,  1'b0, '0},
    // Limit extreme, ID width below and above range, wrap at the top.
    '{ROW_WRITE, REG_ERROR_LIMIT, 17'd255, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_WRITE, REG_ID_BITS,     17'd0, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_WRITE, REG_LAST_ID,     17'd65535, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd0,    4'd1,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'hFFFF, 4'd2,  1'b0, '0},
    '{ROW_WRITE, REG_ID_BITS,     17'd31, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'hFFFF, 4'd1,  1'b0, '0},
    // Most negative reference ID means none is known.
    '{ROW_WRITE, REG_LAST_ID,     17'h10000, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd1,    4'd1,  1'b0, '0},
    '{ROW_WRITE, REG_ID_BITS,     17'd16, 16'h0000, 4'd0, 1'b0, '0},
    '{ROW_WRITE, REG_MAX_FRAMES,  17'd0, 16'h0000, 4'd0,  1'b0, '0},
    '{ROW_ITEM,  REG_ERROR_LIMIT, 17'd0, 16'd1,    4'd1,  1'b1, '{16'h0, 3'd0, 1'b0, ST_UNCFG}}
  };

  // Empties the slots and restarts the group position.
  function automatic void empty_slots();
    group_pos = 0;
    foreach (slot_ids[i]) slot_ids[i] = -17'sd1;
  endfunction

  function automatic void restart_tracking();
    empty_slots();
    awaiting_first = 1'b1;
    repair_run     = '0;
  endfunction

  function automatic int frames_in_use();
    return (int'(conf_max_frames) > NUM_SLOTS) ? NUM_SLOTS : int'(conf_max_frames);
  endfunction

  function automatic int id_modulus();
    int bits;
    bits = (conf_id_bits == 0) ? 1 : ((conf_id_bits > 16) ? 16 : int'(conf_id_bits));
    return 1 << bits;
  endfunction

  function automatic void count_repair();
    if (repair_run != 8'hFF) repair_run = repair_run + 8'd1;
  endfunction

  // First occupied slot of the current group, or -1 when the group is empty.
  function automatic int group_head();
    for (int i = 0; i < frames_in_use(); i++) begin
      if (slot_ids[i] >= 0) return int'(slot_ids[i]);
    end
    return -1;
  endfunction

  // Places one frame in the group, repairing the ID or the frame number when
  // only one of them disagrees. Returns 0 when out of range or both disagree.
  function automatic bit place_in_group(input int id_in, input int fn_in,
                                        output int out_id, output int out_fn,
                                        output bit out_valid);
    int frames, pos_idx, id, fn;
    bit wrong_id, wrong_fn;
    frames    = frames_in_use();
    id        = id_in;
    fn        = fn_in;
    wrong_id  = 1'b0;
    wrong_fn  = 1'b0;
    out_valid = 1'b0;
    out_id    = 0;
    out_fn    = 0;
    if (fn == 0 || fn > frames) return 1'b0;
    pos_idx = fn - 1;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      group_pos      = pos_idx;
    end else begin
      if (group_pos != pos_idx) begin
        wrong_fn = 1'b1;
        pos_idx  = group_pos;
      end
      if (pos_idx > 0 && int'(slot_ids[0]) != id) wrong_id = 1'b1;
      if (!(wrong_id && wrong_fn)) begin
        if (wrong_fn) fn = group_pos + 1;
        if (wrong_id) id = int'(slot_ids[0]);
      end
    end
    if (pos_idx >= NUM_SLOTS) pos_idx = NUM_SLOTS - 1;
    slot_ids[pos_idx] = 17'(id);
    group_pos++;
    out_id    = id;
    out_fn    = fn;
    out_valid = 1'b1;
    if (group_pos >= frames) empty_slots();
    return !(wrong_id && wrong_fn);
  endfunction

  // Works out the corrected ID, frame and status for one input item.
  function automatic result_t fix_item(input logic [ID_W-1:0] raw_id,
                                       input logic [FN_IN_W-1:0] raw_fn);
    result_t res;
    status_t st;
    int      cur, fn, out_id, out_fn, grp, modulus, wrapped, delta, repaired, last_ref;
    bit      out_valid;
    cur       = int'(raw_id);
    fn        = int'(raw_fn);
    out_id    = 0;
    out_fn    = 0;
    out_valid = 1'b0;
    if (conf_max_frames == 0) begin
      st = ST_UNCFG;
    end else if (conf_last_id < 0) begin
      st = place_in_group(cur, fn, out_id, out_fn, out_valid) ? ST_OK : ST_FAIL;
    end else begin
      last_ref = int'(conf_last_id);
      grp      = group_head();
      if (grp >= 0 && grp <= cur) begin
        if (!place_in_group(cur, fn, out_id, out_fn, out_valid)) count_repair();
      end else begin
        // Check against the reference ID, modulo the ID width.
        modulus = id_modulus();
        wrapped = (cur < last_ref) ? cur + modulus : cur;
        delta   = wrapped - last_ref;
        if (delta == 0) begin
          repaired = wrapped + 1;
          count_repair();
        end else if (delta > 2) begin
          repaired = last_ref + 1;
          count_repair();
        end else begin
          repaired   = cur;
          repair_run = '0;
        end
        repaired = repaired % modulus;
        void'(place_in_group(repaired, fn, out_id, out_fn, out_valid));
      end
      st = (repair_run >= conf_error_limit) ? ST_FAIL : ST_OK;
    end
    res.fixed_id    = out_valid ? out_id[ID_W-1:0] : '0;
    res.fixed_frame = out_valid ? out_fn[FN_OUT_W-1:0] : '0;
    res.fixed_valid = out_valid;
    res.status      = st;
    return res;
  endfunction

  function automatic void apply_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_ERROR_LIMIT: conf_error_limit = v[ELIM_W-1:0];
      REG_MAX_FRAMES: begin
        conf_max_frames = v[MAXF_W-1:0];
        restart_tracking();
      end
      REG_ID_BITS:     conf_id_bits = v[IDB_W-1:0];
      REG_LAST_ID:     conf_last_id = $signed(v);
      default: ;
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // One register write; the block is idle whenever this is called.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_addr  <= idx;
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    apply_write(idx, v);
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one item, records its expected result once the transaction completes.
  task automatic send_item(input logic [ID_W-1:0] item_id, input logic [FN_IN_W-1:0] frame_no,
                           input bit typed, input result_t want, input int gap);
    result_t predicted;
    s_axis_tdata  <= {4'b0000, frame_no, item_id};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predicted = fix_item(item_id, frame_no);
    pending_fixes.push_back(typed ? want : predicted);
    n_items++;
    if (predicted.status == ST_FAIL) n_flagged++;
    if (predicted.status == ST_UNCFG) n_uncfg++;
    else if (!predicted.fixed_valid) n_invalid++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items until every expected result has come back.
  task automatic drain(input int settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_fixes.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off on request.
  initial begin
    int stall_left;
    int len;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        m_axis_tready <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
        hold_req   = 1'b0;
        n_holds++;
      end else begin
        len = quiet ? 0 : pick_gap();
        if (len > 0) begin
          m_axis_tready <= 1'b0;
          stall_left = len - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_fixes.size() == 0) begin
        $error("result with no item outstanding: tdata %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_fixes.pop_front();
        n_results++;
        if (m_axis_tdata[15:0] !== want.fixed_id) begin
          $error("fixed_id: expected %0d, got %0d", want.fixed_id, m_axis_tdata[15:0]);
          n_errors++;
        end
        if (m_axis_tdata[18:16] !== want.fixed_frame) begin
          $error("fixed_frame: expected %0d, got %0d", want.fixed_frame, m_axis_tdata[18:16]);
          n_errors++;
        end
        if (m_axis_tdata[19] !== want.fixed_valid) begin
          $error("fixed_valid: expected %0d, got %0d", want.fixed_valid, m_axis_tdata[19]);
          n_errors++;
        end
        if (m_axis_tdata[21:20] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[21:20]);
          n_errors++;
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases of settings and items.
  initial begin
    dir_row_t              row;
    int                    budget, sent, mf, modulus, seq_id, r;
    logic [ID_W-1:0]       item_id;
    logic [FN_IN_W-1:0]    frame_no;
    logic [CFG_DATA_W-1:0] v;
    bit                    paused;
    restart_tracking();
    seq_id = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain(SETTLE);
        write_reg(row.idx, row.value);
      end else begin
        send_item(row.item_id, row.frame_no, row.typed, row.want, pick_gap());
      end
    end

    // Random phases: new settings between phases, then mostly well-formed groups.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain(SETTLE);
      if (p == 0 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 4))
          0:       v = 17'd0;
          1:       v = 17'd255;
          2:       v = 17'($urandom_range(1, 3));
          default: v = 17'($urandom_range(0, 255));
        endcase
        write_reg(REG_ERROR_LIMIT, v);
      end
      if (p == 0 || $urandom_range(0, 2) != 0) begin
        r = int'($urandom_range(0, 99));
        if (r < 10)      v = 17'd0;
        else if (r < 20) v = 17'($urandom_range(5, 7));
        else             v = 17'($urandom_range(1, 4));
        write_reg(REG_MAX_FRAMES, v);
      end
      if (p == 0 || $urandom_range(0, 1) == 1) begin
        r = int'($urandom_range(0, 99));
        if (r < 40)      v = 17'd16;
        else if (r < 48) v = 17'd0;
        else if (r < 55) v = 17'($urandom_range(17, 31));
        else             v = 17'($urandom_range(1, 15));
        write_reg(REG_ID_BITS, v);
      end
      if (p == 0 || $urandom_range(0, 1) == 1) begin
        r = int'($urandom_range(0, 99));
        if (r < 30)      v = 17'h1FFFF;
        else if (r < 40) v = {1'b1, 16'($urandom)};
        else if (r < 50) v = ($urandom_range(0, 1) == 1) ? 17'd65535 : 17'd0;
        else             v = 17'($urandom_range(0, id_modulus() - 1));
        write_reg(REG_LAST_ID, v);
      end

      quiet  = (p == HOLD_PHASE) || ($urandom_range(0, 4) == 0);
      budget = int'($urandom_range(40, 70));
      sent   = 0;
      paused = 1'b0;
      // Keep offering items back to back while the receiver holds off.
      if (p == HOLD_PHASE) hold_req = 1'b1;

      while (sent < budget) begin
        mf = frames_in_use();
        if (mf == 0) mf = int'($urandom_range(1, 4));
        modulus = id_modulus();
        if ($urandom_range(0, 99) < 75) begin
          // A whole group with one ID near the reference, or the next in sequence.
          if (conf_last_id >= 0 && $urandom_range(0, 2) != 0)
            seq_id = (int'(conf_last_id) + int'($urandom_range(0, 3))) % modulus;
          else
            seq_id = (seq_id + 1) % modulus;
          for (int f = 1; f <= mf; f++) begin
            item_id  = seq_id[ID_W-1:0];
            frame_no = f[FN_IN_W-1:0];
            case ($urandom_range(0, 19))
              0: item_id  = 16'($urandom);
              1: frame_no = 4'($urandom_range(0, 15));
              2: begin
                item_id  = item_id + 16'd1;
                frame_no = 4'($urandom_range(0, 15));
              end
              3: item_id  = item_id + 16'd1;
              default: ;
            endcase
            send_item(item_id, frame_no, 1'b0, '0, quiet ? 0 : pick_gap());
            sent++;
          end
        end else begin
          // Noise: any ID and any frame number.
          item_id  = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom % modulus);
          frame_no = 4'($urandom_range(0, 15));
          send_item(item_id, frame_no, 1'b0, '0, quiet ? 0 : pick_gap());
          sent++;
        end
        // Once, hold back the input until every expected result has come.
        if (p == PAUSE_PHASE && !paused && sent >= budget / 2) begin
          drain(0);
          paused = 1'b1;
        end
      end
    end

    // Let the pipeline empty, then report.
    drain(END_SETTLE);
    quiet = 1'b0;
    $display("Summary: %0d items sent, %0d results checked, %0d register writes, %0d hold-offs.",
             n_items, n_results, n_writes, n_holds);
    $display("Summary: %0d flagged failed, %0d unconfigured, %0d with frame out of range.",
             n_flagged, n_uncfg, n_invalid);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin
    #2_000_000;
    $error("timed out with %0d results still expected", pending_fixes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sidf_pkg.sv
design/sidf_cfg_regs.sv
design/sidf_fix_core.sv
design/sequence_id_frame_fixer_top.sv
design/sidf_checker.sv
tb/sv/tb_top.sv
